// ----- hw/rtl/bae_pkg.sv -----
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types and constants for the binary arithmetic encoder: word
// structs, sequencer states, packer commands and the probability clamp.
// ----------------------------------------------------------------------------
package bae_pkg;

  localparam int CODE_BITS_DEF  = 32;
  localparam int FOLLOW_MAX_DEF = 255;

  // One word per item is reserved for the count-only result.
  localparam int MAX_RESULTS = 40;
  localparam int MAX_BYTES   = MAX_RESULTS - 1;
  localparam int BUF_AW      = $clog2(MAX_BYTES + 1);

  localparam logic [31:0] PROB_UNIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] SCALED_MIN = 32'd429496;
  localparam logic [31:0] SCALED_MAX = 32'd4294537798;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef struct packed {
    logic        operation;
    logic        symbol_bit;
    logic [31:0] prob_one;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        last;
    logic [31:0] symbol_count;
    logic        follow_overflow;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DIV1,
    S_DIV2,
    S_SPLIT,
    S_RENORM,
    S_FOLLOW,
    S_FIN,
    S_FLUSH,
    S_RD,
    S_OUT,
    S_CNT
  } state_t;

  typedef struct packed {
    logic start;
    logic bit_en;
    logic bit_val;
    logic flush;
  } pack_cmd_t;

endpackage

// ----- hw/rtl/bae_pack.sv -----
// ----------------------------------------------------------------------------
// bae_pack
// Packs code bits LSB-first into bytes and stores the finished bytes of one
// item in a small buffer that the sequencer reads back afterwards.
// ----------------------------------------------------------------------------
module bae_pack (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bae_pkg::pack_cmd_t        cmd,
  input  logic                      rd_en,
  input  logic [bae_pkg::BUF_AW-1:0] rd_addr,
  output logic [7:0]                rd_data,
  output logic [bae_pkg::BUF_AW-1:0] byte_count
);
  import bae_pkg::*;

  logic [7:0]        acc_r, acc_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic [BUF_AW-1:0] cnt_r, cnt_nxt;
  logic [7:0]        acc_with;
  logic              room;
  logic              wr_en;
  logic [7:0]        wr_data;
  logic [7:0]        mem [MAX_BYTES];
  logic [7:0]        rd_data_r;

  always_comb begin
    acc_with = acc_r | (8'(cmd.bit_val) << pos_r);
    room     = (cnt_r < BUF_AW'(MAX_BYTES));
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    wr_en    = 1'b0;
    wr_data  = acc_with;
    if (cmd.start) begin
      cnt_nxt = '0;
    end else if (cmd.bit_en) begin
      if (pos_r == 3'd7) begin
        // A full byte past the buffer limit is dropped, but the packer still clears.
        wr_en   = room;
        acc_nxt = '0;
        pos_nxt = '0;
      end else begin
        acc_nxt = acc_with;
        pos_nxt = pos_r + 3'd1;
      end
    end else if (cmd.flush) begin
      wr_data = acc_r;
      wr_en   = (pos_r != 3'd0) && room;
      acc_nxt = '0;
      pos_nxt = '0;
    end
    if (wr_en) begin
      cnt_nxt = cnt_r + BUF_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pos_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data    = rd_data_r;
  assign byte_count = cnt_r;

endmodule

// ----- hw/rtl/binary_arithmetic_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_unit
// Encode: the split runs as multiply, add, two reduction steps and narrow,
// then the interval rescales step by step until it is found settled, with
// the pending follow bits sent after each decided bit; each result word is
// then read from the buffer and offered, and the unit returns to idle.
// Finish: the termination bits with the pending follow bits, then the
// flush, then each byte and the count word. One item at a time;
// ready only while idle.
// Synchronous active-low reset returns the coder to the full interval.
// ----------------------------------------------------------------------------
module binary_arithmetic_encoder_unit #(
  parameter int CODE_BITS  = bae_pkg::CODE_BITS_DEF,
  parameter int FOLLOW_MAX = bae_pkg::FOLLOW_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bae_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bae_pkg::out_word_t out_data
);
  import bae_pkg::*;

  localparam int CB  = CODE_BITS;
  localparam int PW  = CB + 32;
  localparam int PFW = $clog2(FOLLOW_MAX + 1);
  localparam int FW  = $clog2(FOLLOW_MAX + 2);

  state_t            state_r, state_nxt;
  logic [CB-1:0]     low_r, low_nxt;
  logic [CB-1:0]     high_r, high_nxt;
  logic [PFW-1:0]    pend_r, pend_nxt;
  logic [FW-1:0]     fleft_r, fleft_nxt;
  logic              fbit_r, fbit_nxt;
  logic              fin_r, fin_nxt;
  logic [31:0]       count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [BUF_AW-1:0] rd_ptr_r, rd_ptr_nxt;

  logic [31:0]       scaled_r, scaled_nxt;
  logic [CB:0]       range_r, range_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [CB-1:0]     a_r, a_nxt;
  logic [32:0]       s_r, s_nxt;
  logic [32:0]       t_r, t_nxt;
  logic [CB-1:0]     q_r, q_nxt;
  logic              bit_r, bit_nxt;

  logic [31:0]       prob_inv;
  logic [31:0]       scaled_clamp;
  logic [PW-1:0]     mul_w;
  logic [CB-1:0]     split;
  logic              byte_last;
  logic              rd_en;
  logic [7:0]        rd_data;
  logic [BUF_AW-1:0] byte_count;
  pack_cmd_t         cmd;

  bae_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rd_en      (rd_en),
    .rd_addr    (rd_ptr_r),
    .rd_data    (rd_data),
    .byte_count (byte_count)
  );

  assign prob_inv     = PROB_UNIT - in_data.prob_one;
  assign scaled_clamp = (prob_inv < SCALED_MIN) ? SCALED_MIN :
                        (prob_inv > SCALED_MAX) ? SCALED_MAX : prob_inv;
  assign mul_w        = range_r[CB-1:0] * scaled_r;
  // Quotient by 2^32-1 is a + c plus one when the final remainder reaches the divisor.
  assign split        = low_r + q_r + CB'(t_r >= 33'(PROB_UNIT));
  assign byte_last    = !fin_r && (BUF_AW'(rd_ptr_r + BUF_AW'(1)) == byte_count);

  always_comb begin
    state_nxt  = state_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    pend_nxt   = pend_r;
    fleft_nxt  = fleft_r;
    fbit_nxt   = fbit_r;
    fin_nxt    = fin_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    rd_ptr_nxt = rd_ptr_r;
    scaled_nxt = scaled_r;
    range_nxt  = range_r;
    p_nxt      = p_r;
    a_nxt      = a_r;
    s_nxt      = s_r;
    t_nxt      = t_r;
    q_nxt      = q_r;
    bit_nxt    = bit_r;
    cmd        = '0;
    rd_en      = 1'b0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          rd_ptr_nxt = '0;
          fin_nxt    = (in_data.operation == OP_FINISH);
          bit_nxt    = in_data.symbol_bit;
          scaled_nxt = scaled_clamp;
          range_nxt  = {1'b0, high_r} - {1'b0, low_r} + (CB+1)'(1);
          state_nxt  = (in_data.operation == OP_FINISH) ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        p_nxt     = mul_w;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        // The top range bit is set only for the full interval, where the low part is zero.
        if (range_r[CB]) begin
          p_nxt = p_r + {scaled_r, {CB{1'b0}}};
        end
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        a_nxt     = p_r[PW-1:32];
        s_nxt     = 33'(p_r[PW-1:32]) + 33'(p_r[31:0]);
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        t_nxt     = 33'(s_r[32]) + 33'(s_r[31:0]);
        q_nxt     = a_r + CB'(s_r[32]);
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        if (bit_r) begin
          low_nxt = split;
        end else begin
          high_nxt = split - CB'(1);
        end
        state_nxt = S_RENORM;
      end
      S_RENORM: begin
        if (!high_r[CB-1] || low_r[CB-1]) begin
          // Lower or upper half: the bit is decided, the top bit shifts out.
          cmd.bit_en  = 1'b1;
          cmd.bit_val = low_r[CB-1];
          low_nxt     = {low_r[CB-2:0], 1'b0};
          high_nxt    = {high_r[CB-2:0], 1'b1};
          if (pend_r != '0) begin
            fleft_nxt = FW'(pend_r);
            fbit_nxt  = low_r[CB-1];
            pend_nxt  = '0;
            state_nxt = S_FOLLOW;
          end
        end else if (low_r[CB-2] && !high_r[CB-2]) begin
          // Middle straddle: defer a follow bit or flag overflow, expand around the center.
          if (pend_r >= PFW'(FOLLOW_MAX)) begin
            ovf_nxt = 1'b1;
          end else begin
            pend_nxt = pend_r + PFW'(1);
          end
          low_nxt  = {1'b0, low_r[CB-3:0], 1'b0};
          high_nxt = {1'b1, high_r[CB-3:0], 1'b1};
        end else begin
          if (count_r != '1) begin
            count_nxt = count_r + 32'd1;
          end
          state_nxt = S_RD;
        end
      end
      S_FOLLOW: begin
        if (fleft_r != '0) begin
          cmd.bit_en  = 1'b1;
          cmd.bit_val = !fbit_r;
          fleft_nxt   = fleft_r - FW'(1);
        end else begin
          state_nxt = fin_r ? S_FLUSH : S_RENORM;
        end
      end
      S_FIN: begin
        cmd.bit_en  = 1'b1;
        cmd.bit_val = low_r[CB-1] | low_r[CB-2];
        fbit_nxt    = low_r[CB-1] | low_r[CB-2];
        fleft_nxt   = FW'(pend_r) + FW'(1);
        state_nxt   = S_FOLLOW;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (rd_ptr_r == byte_count) begin
          state_nxt = fin_r ? S_CNT : S_IDLE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          rd_ptr_nxt = rd_ptr_r + BUF_AW'(1);
          state_nxt  = S_RD;
        end
      end
      S_CNT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          low_nxt   = '0;
          high_nxt  = '1;
          pend_nxt  = '0;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data.out_byte        = (state_r == S_OUT) ? rd_data : 8'd0;
    out_data.has_byte        = (state_r == S_OUT);
    out_data.last            = (state_r == S_CNT) || byte_last;
    out_data.symbol_count    = count_r;
    out_data.follow_overflow = ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      low_r    <= '0;
      high_r   <= '1;
      pend_r   <= '0;
      fleft_r  <= '0;
      fin_r    <= 1'b0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      rd_ptr_r <= '0;
    end else begin
      state_r  <= state_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      pend_r   <= pend_nxt;
      fleft_r  <= fleft_nxt;
      fin_r    <= fin_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fbit_r   <= fbit_nxt;
    scaled_r <= scaled_nxt;
    range_r  <= range_nxt;
    p_r      <= p_nxt;
    a_r      <= a_nxt;
    s_r      <= s_nxt;
    t_r      <= t_nxt;
    q_r      <= q_nxt;
    bit_r    <= bit_nxt;
  end

  a_ready_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a result word is offered");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready again right after accepting a word");

  a_count_word_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_byte) |-> out_data.last)
    else $error("count-only word not marked last");

  a_interval_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (low_r <= high_r))
    else $error("interval low above high while idle");

endmodule
